// ===== design/lwfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lwfs_pkg
// Shared types and constants of the LCD window fill sequencer.
// ----------------------------------------------------------------------------
package lwfs_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CFG_IDX_CMD_SET = 8'd0;
  localparam logic [7:0] CFG_IDX_MIRROR  = 8'd1;

  // Command-set mode codes.
  localparam logic [15:0] CMD_COLUMN_ADDR = 16'h002A;
  localparam logic [15:0] CMD_PAGE_ADDR   = 16'h002B;
  localparam logic [15:0] CMD_MEM_WRITE   = 16'h002C;

  // Register mode indexes.
  localparam logic [15:0] REG_H_START  = 16'h0050;
  localparam logic [15:0] REG_H_END    = 16'h0051;
  localparam logic [15:0] REG_V_START  = 16'h0052;
  localparam logic [15:0] REG_V_END    = 16'h0053;
  localparam logic [15:0] REG_CURSOR_X = 16'h0020;
  localparam logic [15:0] REG_CURSOR_Y = 16'h0021;
  localparam logic [15:0] REG_WRITE_RAM = 16'h0022;

  localparam logic [15:0] BYTE_MASK = 16'h00FF;

  // Width of the repeat count on the output.
  localparam int unsigned CNT_W = 17;

  // Sequencer step of the pixel-data word in each mode.
  localparam logic [3:0] STEP_PIXEL_CMD = 4'd11;
  localparam logic [3:0] STEP_PIXEL_REG = 4'd14 - 4'd1;

  // One classified rectangle, ready for the bus sequencer.
  typedef struct packed {
    logic             cmd_set;  // byte-split command set selected
    logic [15:0]      xa;       // first column word (x0, or mirrored start)
    logic [15:0]      xb;       // second column word (x1, or mirrored end)
    logic [15:0]      ya;       // top row
    logic [15:0]      yb;       // bottom row
    logic [15:0]      color;
    logic [CNT_W-1:0] count;    // clipped width times height
  } lwfs_job_t;

endpackage

// ===== design/lcd_window_fill_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// lcd_window_fill_sequencer_top
// Turns rectangle fills into 8080-bus word runs that set up the address
// window and end in one pixel word carrying the repeat count.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one rectangle per transfer. A rectangle with an
// off-screen origin or a zero size is taken and produces nothing. Every
// other one yields a run on the master stream: 12 words in command-set mode
// or 14 words in register mode, the last one flagged by tlast and carrying
// the clipped width times height as its repeat count.
// A taken rectangle passes the front register and the job queue before the
// first word of its run is registered at the output. The sequencer issues
// one word per cycle while the receiver keeps up and runs straight from one
// rectangle into the next. A two-entry queue lets the input keep taking
// rectangles while the sequencer works through a run.
// When the receiver stalls, the output word holds and the queue fills; the
// input then stalls in turn. Reset clears the mode registers to register
// mode without mirroring and empties every stage.
// The configuration channel is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module lcd_window_fill_sequencer_top
  import lwfs_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 320
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic        cfg_data_i,
  // Rectangle stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // left, top, span_x, span_y, color
  // Bus word stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // bus_word, repeat_res, zero padding
  output logic        m_axis_tuser,  // is_data
  output logic        m_axis_tlast   // last
);

  logic             cmd_set_q, mirror_q;
  logic             job_valid, job_ready;
  lwfs_job_t        job_in, job_out;
  logic             q_valid, q_ready;
  logic [15:0]      out_word;
  logic [CNT_W-1:0] out_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_set_q <= 1'b0;
      mirror_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IDX_CMD_SET) begin
        cmd_set_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_IDX_MIRROR) begin
        mirror_q <= cfg_data_i;
      end
    end
  end

  lwfs_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_set_i   (cmd_set_q),
    .mirror_i    (mirror_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .left_i      (s_axis_tdata[15:0]),
    .top_i       (s_axis_tdata[31:16]),
    .span_x_i    (s_axis_tdata[47:32]),
    .span_y_i    (s_axis_tdata[63:48]),
    .color_i     (s_axis_tdata[79:64]),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job_in)
  );

  lwfs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job_in),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (job_out)
  );

  lwfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_ready_o   (q_ready),
    .job_i         (job_out),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_is_data_o (m_axis_tuser),
    .out_word_o    (out_word),
    .out_count_o   (out_count),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_count, out_word};

endmodule

// ===== design/lwfs_front.sv =====
// ----------------------------------------------------------------------------
// lwfs_front
// Accepts rectangles, drops off-screen or empty ones, clips the size and
// forms the window corners and pixel count for the sequencer.
// ----------------------------------------------------------------------------
module lwfs_front
  import lwfs_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 320
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_set_i,
  input  logic        mirror_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] left_i,
  input  logic [15:0] top_i,
  input  logic [15:0] span_x_i,
  input  logic [15:0] span_y_i,
  input  logic [15:0] color_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output lwfs_job_t   job_o
);

  localparam int unsigned XW = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned YW = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned PW = XW + YW;
  localparam logic [XW-1:0] XMAX = XW'(SCREEN_WIDTH - 1);

  logic          reject;
  logic [16:0]   rem_x, rem_y;
  logic [15:0]   w_clip, h_clip;
  logic          load;

  logic          s1_valid_q, s1_valid_d;
  logic [XW-1:0] x0_q, w_q;
  logic [YW-1:0] y0_q, h_q;
  logic [15:0]   color_q;

  logic [XW-1:0] x1, sx0, sx1;
  logic [YW-1:0] y1;
  logic [PW-1:0] prod;

  assign reject = ({1'b0, left_i} >= 17'(SCREEN_WIDTH)) ||
                  ({1'b0, top_i} >= 17'(SCREEN_HEIGHT)) ||
                  (span_x_i == 16'd0) || (span_y_i == 16'd0);

  // Room left from the origin to the screen edge; only meaningful when the
  // origin is on screen, which is all that is kept.
  assign rem_x  = 17'(SCREEN_WIDTH) - {1'b0, left_i};
  assign rem_y  = 17'(SCREEN_HEIGHT) - {1'b0, top_i};
  assign w_clip = ({1'b0, span_x_i} > rem_x) ? rem_x[15:0] : span_x_i;
  assign h_clip = ({1'b0, span_y_i} > rem_y) ? rem_y[15:0] : span_y_i;

  assign in_ready_o = !s1_valid_q || job_ready_i;
  assign load       = in_valid_i && in_ready_o && !reject;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_ready_o) begin
      s1_valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x0_q    <= XW'(left_i);
      y0_q    <= YW'(top_i);
      w_q     <= XW'(w_clip);
      h_q     <= YW'(h_clip);
      color_q <= color_i;
    end
  end

  assign x1   = x0_q + w_q - XW'(1);
  assign y1   = y0_q + h_q - YW'(1);
  assign sx0  = XMAX - x1;
  assign sx1  = XMAX - x0_q;
  assign prod = PW'(w_q) * PW'(h_q);

  always_comb begin
    job_o.cmd_set = cmd_set_i;
    if (!cmd_set_i && mirror_i) begin
      job_o.xa = 16'(sx0);
      job_o.xb = 16'(sx1);
    end else begin
      job_o.xa = 16'(x0_q);
      job_o.xb = 16'(x1);
    end
    job_o.ya    = 16'(y0_q);
    job_o.yb    = 16'(y1);
    job_o.color = color_q;
    job_o.count = CNT_W'(prod);
  end

  assign job_valid_o = s1_valid_q;

endmodule

// ===== design/lwfs_fifo.sv =====
// ----------------------------------------------------------------------------
// lwfs_fifo
// Two-entry job queue between the classifier and the bus sequencer.
// ----------------------------------------------------------------------------
module lwfs_fifo
  import lwfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  lwfs_job_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output lwfs_job_t pop_data_o
);

  lwfs_job_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/lwfs_back.sv =====
// ----------------------------------------------------------------------------
// lwfs_back
// Bus sequencer: walks each job through its window setup words and the
// final pixel word into a registered output, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module lwfs_back
  import lwfs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  lwfs_job_t        job_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_is_data_o,
  output logic [15:0]      out_word_o,
  output logic [CNT_W-1:0] out_count_o,
  output logic             out_last_o
);

  logic [3:0]       step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic             is_data_q, is_data_d;
  logic [15:0]      word_q, word_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             last_q, last_d;
  logic             advance, final_step;
  logic [3:0]       pixel_step;

  assign advance    = job_valid_i && (!out_valid_q || out_ready_i);
  assign pixel_step = job_i.cmd_set ? STEP_PIXEL_CMD : STEP_PIXEL_REG;
  assign final_step = (step_q == pixel_step);
  assign job_ready_o = advance && final_step;

  // Word selection for the current step of the head job.
  always_comb begin
    is_data_d = 1'b0;
    word_d    = 16'd0;
    count_d   = CNT_W'(1);
    last_d    = 1'b0;
    if (final_step) begin
      is_data_d = 1'b1;
      word_d    = job_i.color;
      count_d   = job_i.count;
      last_d    = 1'b1;
    end else if (job_i.cmd_set) begin
      case (step_q)
        4'd0:    word_d = CMD_COLUMN_ADDR;
        4'd1:    word_d = (job_i.xa >> 8) & BYTE_MASK;
        4'd2:    word_d = job_i.xa & BYTE_MASK;
        4'd3:    word_d = (job_i.xb >> 8) & BYTE_MASK;
        4'd4:    word_d = job_i.xb & BYTE_MASK;
        4'd5:    word_d = CMD_PAGE_ADDR;
        4'd6:    word_d = (job_i.ya >> 8) & BYTE_MASK;
        4'd7:    word_d = job_i.ya & BYTE_MASK;
        4'd8:    word_d = (job_i.yb >> 8) & BYTE_MASK;
        4'd9:    word_d = job_i.yb & BYTE_MASK;
        default: word_d = CMD_MEM_WRITE;
      endcase
      is_data_d = !((step_q == 4'd0) || (step_q == 4'd5) || (step_q == 4'd10));
    end else begin
      // Register mode alternates index and data, the data on odd steps.
      is_data_d = step_q[0];
      case (step_q)
        4'd0:    word_d = REG_H_START;
        4'd1:    word_d = job_i.xa;
        4'd2:    word_d = REG_H_END;
        4'd3:    word_d = job_i.xb;
        4'd4:    word_d = REG_V_START;
        4'd5:    word_d = job_i.ya;
        4'd6:    word_d = REG_V_END;
        4'd7:    word_d = job_i.yb;
        4'd8:    word_d = REG_CURSOR_X;
        4'd9:    word_d = job_i.xa;
        4'd10:   word_d = REG_CURSOR_Y;
        4'd11:   word_d = job_i.ya;
        default: word_d = REG_WRITE_RAM;
      endcase
    end
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      step_d      = final_step ? 4'd0 : step_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      is_data_q <= is_data_d;
      word_q    <= word_d;
      count_q   <= count_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_is_data_o = is_data_q;
  assign out_word_o    = word_q;
  assign out_count_o   = count_q;
  assign out_last_o    = last_q;

endmodule

// ===== test/lwfs_checker.sv =====
// ----------------------------------------------------------------------------
// lwfs_checker
// Watches the configuration, rectangle and bus word channels of the LCD
// window fill sequencer. It works out the bus word run of every rectangle
// taken and compares each word that leaves the block with the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module lwfs_checker
  import lwfs_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 320
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic        cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [79:0] s_tdata_i,   // left, top, span_x, span_y, color
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,   // bus_word, repeat_res, zero padding
  input  logic        m_tuser_i,   // is_data
  input  logic        m_tlast_i,   // last
  output int unsigned errors_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             is_data;
    logic [15:0]      word;
    logic [CNT_W-1:0] repeats;
    logic             fin;
  } bus_word_t;

  bus_word_t   expected_words[$];
  logic        cmd_set_mode = 1'b0;
  logic        mirror_x     = 1'b0;
  int unsigned error_count  = 0;

  function automatic bus_word_t setup_word(logic is_data, logic [15:0] value);
    bus_word_t b;
    b.is_data = is_data;
    b.word    = value;
    b.repeats = CNT_W'(1);
    b.fin     = 1'b0;
    return b;
  endfunction

  // Appends the whole bus word run of one rectangle, or nothing if it is
  // rejected.
  function automatic void queue_window_run(logic [79:0] rect);
    int unsigned x0, y0, w, h, x1, y1, sx0, sx1;
    bus_word_t   pix;
    x0 = 32'(rect[15:0]);
    y0 = 32'(rect[31:16]);
    w  = 32'(rect[47:32]);
    h  = 32'(rect[63:48]);
    if (x0 >= SCREEN_WIDTH || y0 >= SCREEN_HEIGHT || w == 0 || h == 0) begin
      return;
    end
    // The sums are 32 bits wide, so a huge span cannot wrap round.
    if (x0 + w > SCREEN_WIDTH) begin
      w = SCREEN_WIDTH - x0;
    end
    if (y0 + h > SCREEN_HEIGHT) begin
      h = SCREEN_HEIGHT - y0;
    end
    x1 = x0 + w - 1;
    y1 = y0 + h - 1;
    if (cmd_set_mode) begin
      expected_words.push_back(setup_word(1'b0, CMD_COLUMN_ADDR));
      expected_words.push_back(setup_word(1'b1, 16'(x0 >> 8) & BYTE_MASK));
      expected_words.push_back(setup_word(1'b1, 16'(x0) & BYTE_MASK));
      expected_words.push_back(setup_word(1'b1, 16'(x1 >> 8) & BYTE_MASK));
      expected_words.push_back(setup_word(1'b1, 16'(x1) & BYTE_MASK));
      expected_words.push_back(setup_word(1'b0, CMD_PAGE_ADDR));
      expected_words.push_back(setup_word(1'b1, 16'(y0 >> 8) & BYTE_MASK));
      expected_words.push_back(setup_word(1'b1, 16'(y0) & BYTE_MASK));
      expected_words.push_back(setup_word(1'b1, 16'(y1 >> 8) & BYTE_MASK));
      expected_words.push_back(setup_word(1'b1, 16'(y1) & BYTE_MASK));
      expected_words.push_back(setup_word(1'b0, CMD_MEM_WRITE));
    end else begin
      sx0 = x0;
      sx1 = x1;
      if (mirror_x) begin
        sx0 = SCREEN_WIDTH - 1 - x1;
        sx1 = SCREEN_WIDTH - 1 - x0;
      end
      expected_words.push_back(setup_word(1'b0, REG_H_START));
      expected_words.push_back(setup_word(1'b1, 16'(sx0)));
      expected_words.push_back(setup_word(1'b0, REG_H_END));
      expected_words.push_back(setup_word(1'b1, 16'(sx1)));
      expected_words.push_back(setup_word(1'b0, REG_V_START));
      expected_words.push_back(setup_word(1'b1, 16'(y0)));
      expected_words.push_back(setup_word(1'b0, REG_V_END));
      expected_words.push_back(setup_word(1'b1, 16'(y1)));
      expected_words.push_back(setup_word(1'b0, REG_CURSOR_X));
      expected_words.push_back(setup_word(1'b1, 16'(sx0)));
      expected_words.push_back(setup_word(1'b0, REG_CURSOR_Y));
      expected_words.push_back(setup_word(1'b1, 16'(y0)));
      expected_words.push_back(setup_word(1'b0, REG_WRITE_RAM));
    end
    pix.is_data = 1'b1;
    pix.word    = rect[79:64];
    pix.repeats = CNT_W'(w * h);
    pix.fin     = 1'b1;
    expected_words.push_back(pix);
  endfunction

  always @(posedge clk_i) begin : watch
    bus_word_t got;
    bus_word_t want;
    if (!rst_ni) begin
      cmd_set_mode = 1'b0;
      mirror_x     = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_IDX_CMD_SET: cmd_set_mode = cfg_data_i;
          CFG_IDX_MIRROR:  mirror_x = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        queue_window_run(s_tdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        got.is_data = m_tuser_i;
        got.word    = m_tdata_i[15:0];
        got.repeats = m_tdata_i[16 +: CNT_W];
        got.fin     = m_tlast_i;
        if (expected_words.size() == 0) begin
          $error("bus word transfer with nothing outstanding: tdata %h", m_tdata_i);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.is_data !== want.is_data) begin
            $error("is_data: expected %0d, actual %0d", want.is_data, got.is_data);
            error_count++;
          end
          if (got.word !== want.word) begin
            $error("bus_word: expected %h, actual %h", want.word, got.word);
            error_count++;
          end
          if (got.repeats !== want.repeats) begin
            $error("repeat_res: expected %0d, actual %0d", want.repeats, got.repeats);
            error_count++;
          end
          if (got.fin !== want.fin) begin
            $error("last: expected %0d, actual %0d", want.fin, got.fin);
            error_count++;
          end
        end
      end
    end
    outstanding_o <= expected_words.size();
    errors_o      <= error_count;
  end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives rectangle fills and mode writes into the LCD window fill sequencer
// under random sender gaps and receiver stalls, including one long receiver
// hold-off, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top;
  import lwfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SCREEN_W         = 240;
  localparam int unsigned SCREEN_H         = 320;
  localparam int unsigned RANDOM_PER_PHASE = 92;
  localparam int unsigned DRAIN_CYCLES     = 20;
  localparam int unsigned HOLD_AT          = 150;
  localparam int unsigned HOLD_CYCLES      = 200;
  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam logic [7:0]  CFG_IDX_UNUSED   = 8'd7;

  // Packed so that left sits in the lowest bits, as on s_axis_tdata.
  typedef struct packed {
    logic [15:0] color;
    logic [15:0] span_y;
    logic [15:0] span_x;
    logic [15:0] top;
    logic [15:0] left;
  } rect_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i   = '0;
  logic        cfg_data_i    = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned rects_sent  = 0;
  bit          tx_calm     = 1'b0;

  lcd_window_fill_sequencer_top #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  lwfs_checker #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) bus_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .errors_o     (errors),
    .outstanding_o(outstanding)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lcd_window_fill_sequencer_top test failed");
      $finish;
    end
  end

  function automatic rect_t rect(int unsigned l, int unsigned t, int unsigned w,
                                 int unsigned h, int unsigned c);
    rect_t r;
    r.left   = 16'(l);
    r.top    = 16'(t);
    r.span_x = 16'(w);
    r.span_y = 16'(h);
    r.color  = 16'(c);
    return r;
  endfunction

  // Mostly short spans, some up to the edge, some reaching far past it.
  function automatic int unsigned random_span(int unsigned room);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      return $urandom_range(1, (room < 8) ? room : 8);
    end else if (pick < 8) begin
      return $urandom_range(1, room);
    end
    return $urandom_range(room, 65535);
  endfunction

  function automatic rect_t random_rect();
    rect_t       r;
    int unsigned kind;
    kind     = $urandom_range(0, 99);
    r.color  = 16'($urandom);
    r.left   = 16'($urandom_range(0, SCREEN_W - 1));
    r.top    = 16'($urandom_range(0, SCREEN_H - 1));
    r.span_x = 16'(random_span(SCREEN_W - 32'(r.left)));
    r.span_y = 16'(random_span(SCREEN_H - 32'(r.top)));
    if (kind >= 72 && kind < 86) begin
      r = rect_t'(80'({$urandom, $urandom, $urandom}));
    end else if (kind >= 86 && kind < 93) begin
      if ($urandom_range(0, 1) != 0) begin
        r.left = 16'($urandom_range(SCREEN_W, 65535));
      end else begin
        r.top = 16'($urandom_range(SCREEN_H, 65535));
      end
    end else if (kind >= 93) begin
      if ($urandom_range(0, 1) != 0) begin
        r.span_x = '0;
      end else begin
        r.span_y = '0;
      end
    end
    return r;
  endfunction

  // Leaves tvalid high after the transfer; the next call or end_phase
  // decides what happens to it.
  task automatic send_rect(input rect_t r);
    int unsigned gap;
    if (tx_calm || (rects_sent + 10 >= HOLD_AT && rects_sent < HOLD_AT + 40)) begin
      gap = 0;
    end else begin
      gap = $urandom_range(0, 13);
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    rects_sent++;
  endtask

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 32 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
      end
      send_rect(random_rect());
    end
    tx_calm = 1'b0;
  endtask

  task automatic corner_rects();
    send_rect(rect(0, 0, 1, 1, 'h0000));
    send_rect(rect(SCREEN_W - 1, SCREEN_H - 1, 1, 1, 'hFFFF));
    send_rect(rect(0, 0, 'hFFFF, 'hFFFF, 'h5AA5));
  endtask

  task automatic write_reg(input logic [7:0] index, input logic value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic cmd_set, input logic mirror);
    write_reg(CFG_IDX_CMD_SET, cmd_set);
    write_reg(CFG_IDX_MIRROR, mirror);
    cfg_valid_i <= 1'b0;
  endtask

  // Rejected rectangles leave no trace in the count, so a further drain wait
  // follows before the block is taken as idle.
  task automatic end_phase();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : receiver
    int unsigned stall;
    int unsigned results_seen;
    bit          rx_calm;
    bit          long_hold_done;
    results_seen   = 0;
    rx_calm        = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && rects_sent >= HOLD_AT) begin
        long_hold_done = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 13);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      results_seen++;
      if (results_seen % 64 == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register mode, no mirroring; a write to an unknown index must be ignored.
    write_reg(CFG_IDX_UNUSED, 1'b1);
    set_mode(1'b0, 1'b0);
    corner_rects();
    send_rect(rect(SCREEN_W - 40, 10, 40, 20, 'h1234));
    send_rect(rect(SCREEN_W, 0, 1, 1, 'hFFFF));
    send_rect(rect(0, SCREEN_H, 1, 1, 'hFFFF));
    send_rect(rect(5, 5, 0, 3, 'h00FF));
    send_rect(rect(5, 5, 3, 0, 'hFF00));
    send_rect(rect('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
    run_random(RANDOM_PER_PHASE);
    end_phase();

    set_mode(1'b1, 1'b0);
    corner_rects();
    run_random(RANDOM_PER_PHASE);
    end_phase();

    set_mode(1'b0, 1'b1);
    corner_rects();
    run_random(RANDOM_PER_PHASE);
    end_phase();

    // Mirroring has no effect in command-set mode.
    set_mode(1'b1, 1'b1);
    corner_rects();
    run_random(RANDOM_PER_PHASE);
    end_phase();

    set_mode(1'b0, 1'b0);
    run_random(RANDOM_PER_PHASE);
    end_phase();

    if (errors == 0) begin
      $display("lcd_window_fill_sequencer_top test passed");
    end else begin
      $display("lcd_window_fill_sequencer_top test failed");
    end
    $finish;
  end

endmodule

// ===== lcd_window_fill_sequencer_top.f =====
design/lwfs_pkg.sv
design/lwfs_front.sv
design/lwfs_fifo.sv
design/lwfs_back.sv
design/lcd_window_fill_sequencer_top.sv
test/lwfs_checker.sv
test/tb_top.sv
